FILE: src/damped_spring_force_core_assert.svh
`ifndef DAMPED_SPRING_FORCE_CORE_ASSERT_SVH
`define DAMPED_SPRING_FORCE_CORE_ASSERT_SVH

// same-cycle implication
`define DSF_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DSF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/dsf_pkg.sv
package dsf_pkg;

    localparam int DATA_WIDTH      = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int CFG_INDEX_WIDTH = 1;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_STIFFNESS = 1'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DAMPING   = 1'd1;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] offset_x;
        logic signed [DATA_WIDTH-1:0] offset_y;
        logic signed [DATA_WIDTH-1:0] offset_z;
        logic signed [DATA_WIDTH-1:0] rel_vel_x;
        logic signed [DATA_WIDTH-1:0] rel_vel_y;
        logic signed [DATA_WIDTH-1:0] rel_vel_z;
        logic        [DATA_WIDTH-1:0] rest_length;
    } spring_in_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] force_x;
        logic signed [DATA_WIDTH-1:0] force_y;
        logic signed [DATA_WIDTH-1:0] force_z;
        logic                         zero_length;
        logic                         saturated;
    } spring_out_t;

    function automatic logic [DATA_WIDTH-1:0] magnitude(input logic [DATA_WIDTH-1:0] raw);
        return raw[DATA_WIDTH-1] ? (~raw + DATA_WIDTH'(1)) : raw;
    endfunction

endpackage

FILE: src/dsf_sqrt.sv
module dsf_sqrt #(
    parameter int TAG_WIDTH = 1
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [2*dsf_pkg::DATA_WIDTH-1:0]  in_radicand,
    input  logic [TAG_WIDTH-1:0]              in_tag,
    output logic                              out_valid,
    output logic [dsf_pkg::DATA_WIDTH-1:0]    out_root,
    output logic [TAG_WIDTH-1:0]              out_tag
);
    localparam int W = dsf_pkg::DATA_WIDTH;

    logic                 valid_reg [0:W];
    logic [2*W-1:0]       rad_reg   [0:W];
    logic [W+1:0]         rem_reg   [0:W];
    logic [W-1:0]         root_reg  [0:W];
    logic [TAG_WIDTH-1:0] tag_reg   [0:W];

    assign valid_reg[0] = in_valid;
    assign rad_reg[0]   = in_radicand;
    assign rem_reg[0]   = '0;
    assign root_reg[0]  = '0;
    assign tag_reg[0]   = in_tag;

    for (genvar k = 1; k <= W; k++) begin : g_step
        logic [W+1:0] rem_sh;
        logic [W+1:0] trial;
        logic         fits;

        assign rem_sh = {rem_reg[k-1][W-1:0], rad_reg[k-1][2*W-1 -: 2]};
        assign trial  = {root_reg[k-1], 2'b01};
        assign fits   = (rem_sh >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rad_reg[k]  <= rad_reg[k-1] << 2;
                rem_reg[k]  <= fits ? (rem_sh - trial) : rem_sh;
                root_reg[k] <= {root_reg[k-1][W-2:0], fits};
                tag_reg[k]  <= tag_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg[W];
    assign out_root  = root_reg[W];
    assign out_tag   = tag_reg[W];

endmodule

FILE: src/dsf_div.sv
module dsf_div #(
    parameter int FRAC_BITS = dsf_pkg::FRAC_BITS_DEF,
    parameter int TAG_WIDTH = 1
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [dsf_pkg::DATA_WIDTH-1:0] in_divisor,
    input  logic [dsf_pkg::DATA_WIDTH-1:0] in_dividend [3],
    input  logic [TAG_WIDTH-1:0]           in_tag,
    output logic                           out_valid,
    output logic [dsf_pkg::DATA_WIDTH-1:0] out_divisor,
    output logic [FRAC_BITS:0]             out_quot [3],
    output logic [TAG_WIDTH-1:0]           out_tag
);
    localparam int W = dsf_pkg::DATA_WIDTH;
    localparam int Q = W + FRAC_BITS;

    logic                 valid_reg [0:Q];
    logic [W-1:0]         div_reg   [0:Q];
    logic [TAG_WIDTH-1:0] tag_reg   [0:Q];

    assign valid_reg[0] = in_valid;
    assign div_reg[0]   = in_divisor;
    assign tag_reg[0]   = in_tag;

    for (genvar k = 1; k <= Q; k++) begin : g_ctl
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                div_reg[k] <= div_reg[k-1];
                tag_reg[k] <= tag_reg[k-1];
            end
        end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
        logic [Q-1:0]       num_reg  [0:Q];
        logic [W:0]         rem_reg  [0:Q];
        logic [FRAC_BITS:0] quot_reg [0:Q];

        assign num_reg[0]  = {in_dividend[l], FRAC_BITS'(0)};
        assign rem_reg[0]  = '0;
        assign quot_reg[0] = '0;

        for (genvar k = 1; k <= Q; k++) begin : g_step
            logic [W:0] rem_sh;
            logic       fits;

            assign rem_sh = {rem_reg[k-1][W-1:0], num_reg[k-1][Q-1]};
            assign fits   = (rem_sh >= {1'b0, div_reg[k-1]});

            always_ff @(posedge aclk) begin
                if (en) begin
                    num_reg[k]  <= num_reg[k-1] << 1;
                    rem_reg[k]  <= fits ? (rem_sh - {1'b0, div_reg[k-1]}) : rem_sh;
                    quot_reg[k] <= {quot_reg[k-1][FRAC_BITS-1:0], fits};
                end
            end
        end

        assign out_quot[l] = quot_reg[Q];
    end

    assign out_valid   = valid_reg[Q];
    assign out_divisor = div_reg[Q];
    assign out_tag     = tag_reg[Q];

endmodule

FILE: src/damped_spring_force_core.sv
// Damped spring force, one spring per word: takes one word every cycle while
// the pipeline is not held. Each word passes the input stages, the square-root
// pipeline (one root bit per stage), the direction dividers (one quotient bit
// per stage, three lanes sharing the length) and the output stages; the whole
// pipeline holds while a finished result waits on m_ready. Stiffness and
// damping are written through the cfg port; the user must do so only while the
// core is idle, as the core itself does not enforce this.
module damped_spring_force_core #(
    parameter int FRAC_BITS = dsf_pkg::FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [dsf_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [dsf_pkg::DATA_WIDTH-1:0]      cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  dsf_pkg::spring_in_t                 s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output dsf_pkg::spring_out_t                m_data
);
    localparam int W    = dsf_pkg::DATA_WIDTH;
    localparam int UW   = FRAC_BITS + 1;
    localparam int PW   = W + FRAC_BITS + 3;
    localparam int DW   = PW - FRAC_BITS;
    localparam int K1W  = 2 * W - FRAC_BITS;
    localparam int K2W  = W + DW - FRAC_BITS;
    localparam int FW   = K2W + 2;
    localparam int T1_W = 7 * W + 4;
    localparam int T2_W = 4 * W + 4;

    localparam logic signed [W-1:0] SAT_POS = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] SAT_NEG = {1'b1, {(W-1){1'b0}}};

    logic en;
    logic [W-1:0] stiffness_reg;
    logic [W-1:0] damping_reg;

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stiffness_reg <= '0;
            damping_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                dsf_pkg::REG_STIFFNESS: stiffness_reg <= cfg_wdata;
                dsf_pkg::REG_DAMPING:   damping_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // square offsets
    logic [W-1:0] in_off [3];
    logic [W-1:0] in_vel [3];
    logic [W-1:0] in_mag [3];

    assign in_off[0] = s_data.offset_x;
    assign in_off[1] = s_data.offset_y;
    assign in_off[2] = s_data.offset_z;
    assign in_vel[0] = s_data.rel_vel_x;
    assign in_vel[1] = s_data.rel_vel_y;
    assign in_vel[2] = s_data.rel_vel_z;

    for (genvar i = 0; i < 3; i++) begin : g_mag
        assign in_mag[i] = dsf_pkg::magnitude(in_off[i]);
    end

    logic         p0_valid_reg;
    logic [W-1:0] p0_dmag_reg [3];
    logic [2:0]   p0_dneg_reg;
    logic [2*W-1:0] p0_sq_reg [3];
    logic [W-1:0] p0_vel_reg [3];
    logic [W-1:0] p0_rest_reg;
    logic         p0_zero_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p0_valid_reg <= 1'b0;
        end else if (en) begin
            p0_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                p0_dmag_reg[i] <= in_mag[i];
                p0_dneg_reg[i] <= in_off[i][W-1];
                p0_sq_reg[i]   <= (2*W)'(in_mag[i]) * (2*W)'(in_mag[i]);
                p0_vel_reg[i]  <= in_vel[i];
            end
            p0_rest_reg <= s_data.rest_length;
            p0_zero_reg <= (in_off[0] == '0) && (in_off[1] == '0) && (in_off[2] == '0);
        end
    end

    // sum of squares
    logic           p1_valid_reg;
    logic [2*W-1:0] p1_sum_reg;
    logic [W-1:0]   p1_dmag_reg [3];
    logic [2:0]     p1_dneg_reg;
    logic [W-1:0]   p1_vel_reg [3];
    logic [W-1:0]   p1_rest_reg;
    logic           p1_zero_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (en) begin
            p1_valid_reg <= p0_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_sum_reg  <= p0_sq_reg[0] + p0_sq_reg[1] + p0_sq_reg[2];
            p1_dmag_reg <= p0_dmag_reg;
            p1_dneg_reg <= p0_dneg_reg;
            p1_vel_reg  <= p0_vel_reg;
            p1_rest_reg <= p0_rest_reg;
            p1_zero_reg <= p0_zero_reg;
        end
    end

    // length
    logic [T1_W-1:0] sq_tag_in;
    logic [T1_W-1:0] sq_tag_out;
    logic            sq_valid;
    logic [W-1:0]    sq_len;
    logic [W-1:0]    sq_dmag [3];
    logic [2:0]      sq_dneg;
    logic [W-1:0]    sq_vel [3];
    logic [W-1:0]    sq_rest;
    logic            sq_zero;

    assign sq_tag_in = {p1_dmag_reg[0], p1_dmag_reg[1], p1_dmag_reg[2], p1_dneg_reg,
                        p1_vel_reg[0], p1_vel_reg[1], p1_vel_reg[2], p1_rest_reg,
                        p1_zero_reg};

    dsf_sqrt #(
        .TAG_WIDTH (T1_W)
    ) u_sqrt (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (p1_valid_reg),
        .in_radicand (p1_sum_reg),
        .in_tag      (sq_tag_in),
        .out_valid   (sq_valid),
        .out_root    (sq_len),
        .out_tag     (sq_tag_out)
    );

    assign {sq_dmag[0], sq_dmag[1], sq_dmag[2], sq_dneg,
            sq_vel[0], sq_vel[1], sq_vel[2], sq_rest, sq_zero} = sq_tag_out;

    // direction
    logic [T2_W-1:0] dv_tag_in;
    logic [T2_W-1:0] dv_tag_out;
    logic            dv_valid;
    logic [W-1:0]    dv_len;
    logic [UW-1:0]   dv_quot [3];
    logic [2:0]      dv_dneg;
    logic [W-1:0]    dv_vel [3];
    logic [W-1:0]    dv_rest;
    logic            dv_zero;

    assign dv_tag_in = {sq_dneg, sq_vel[0], sq_vel[1], sq_vel[2], sq_rest, sq_zero};

    dsf_div #(
        .FRAC_BITS (FRAC_BITS),
        .TAG_WIDTH (T2_W)
    ) u_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (sq_valid),
        .in_divisor  (sq_len),
        .in_dividend (sq_dmag),
        .in_tag      (dv_tag_in),
        .out_valid   (dv_valid),
        .out_divisor (dv_len),
        .out_quot    (dv_quot),
        .out_tag     (dv_tag_out)
    );

    assign {dv_dneg, dv_vel[0], dv_vel[1], dv_vel[2], dv_rest, dv_zero} = dv_tag_out;

    // velocity products, stretch
    logic [W-1:0]    dv_vmag [3];
    logic            a_valid_reg;
    logic [W+UW-1:0] a_prod_reg [3];
    logic [2:0]      a_pneg_reg;
    logic [W-1:0]    a_smag_reg;
    logic            a_sneg_reg;
    logic [UW-1:0]   a_umag_reg [3];
    logic [2:0]      a_dneg_reg;
    logic            a_zero_reg;

    for (genvar i = 0; i < 3; i++) begin : g_vmag
        assign dv_vmag[i] = dsf_pkg::magnitude(dv_vel[i]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                a_prod_reg[i] <= (W+UW)'(dv_vmag[i]) * (W+UW)'(dv_quot[i]);
                a_pneg_reg[i] <= dv_vel[i][W-1] ^ dv_dneg[i];
            end
            a_sneg_reg <= dv_rest > dv_len;
            a_smag_reg <= (dv_rest > dv_len) ? (dv_rest - dv_len) : (dv_len - dv_rest);
            a_umag_reg <= dv_quot;
            a_dneg_reg <= dv_dneg;
            a_zero_reg <= dv_zero;
        end
    end

    // dot sum, spring term
    logic signed [PW-1:0] a_term [3];
    logic [2*W-1:0]       a_k1_full;
    logic                 b_valid_reg;
    logic signed [PW-1:0] b_p_reg;
    logic [K1W-1:0]       b_k1_reg;
    logic                 b_sneg_reg;
    logic [UW-1:0]        b_umag_reg [3];
    logic [2:0]           b_dneg_reg;
    logic                 b_zero_reg;

    for (genvar i = 0; i < 3; i++) begin : g_term
        assign a_term[i] = a_pneg_reg[i] ? -$signed(PW'(a_prod_reg[i]))
                                         :  $signed(PW'(a_prod_reg[i]));
    end

    assign a_k1_full = (2*W)'(stiffness_reg) * (2*W)'(a_smag_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (en) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_p_reg    <= a_term[0] + a_term[1] + a_term[2];
            b_k1_reg   <= a_k1_full[2*W-1:FRAC_BITS];
            b_sneg_reg <= a_sneg_reg;
            b_umag_reg <= a_umag_reg;
            b_dneg_reg <= a_dneg_reg;
            b_zero_reg <= a_zero_reg;
        end
    end

    // dot magnitude
    logic [PW-1:0]  b_pabs;
    logic           c_valid_reg;
    logic           c_pneg_reg;
    logic [DW-1:0]  c_dot_reg;
    logic [K1W-1:0] c_k1_reg;
    logic           c_sneg_reg;
    logic [UW-1:0]  c_umag_reg [3];
    logic [2:0]     c_dneg_reg;
    logic           c_zero_reg;

    assign b_pabs = b_p_reg[PW-1] ? PW'(-b_p_reg) : PW'(b_p_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (en) begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_pneg_reg <= b_p_reg[PW-1];
            c_dot_reg  <= b_pabs[PW-1:FRAC_BITS];
            c_k1_reg   <= b_k1_reg;
            c_sneg_reg <= b_sneg_reg;
            c_umag_reg <= b_umag_reg;
            c_dneg_reg <= b_dneg_reg;
            c_zero_reg <= b_zero_reg;
        end
    end

    // damping term
    logic [W+DW-1:0] c_k2_full;
    logic            d_valid_reg;
    logic [K2W-1:0]  d_k2_reg;
    logic            d_pneg_reg;
    logic [K1W-1:0]  d_k1_reg;
    logic            d_sneg_reg;
    logic [UW-1:0]   d_umag_reg [3];
    logic [2:0]      d_dneg_reg;
    logic            d_zero_reg;

    assign c_k2_full = (W+DW)'(damping_reg) * (W+DW)'(c_dot_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (en) begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_k2_reg   <= c_k2_full[W+DW-1:FRAC_BITS];
            d_pneg_reg <= c_pneg_reg;
            d_k1_reg   <= c_k1_reg;
            d_sneg_reg <= c_sneg_reg;
            d_umag_reg <= c_umag_reg;
            d_dneg_reg <= c_dneg_reg;
            d_zero_reg <= c_zero_reg;
        end
    end

    // project onto direction
    logic [K1W+UW-1:0] d_t1_full [3];
    logic [K2W+UW-1:0] d_t2_full [3];
    logic              e_valid_reg;
    logic [K1W-1:0]    e_t1_reg [3];
    logic [K2W-1:0]    e_t2_reg [3];
    logic [2:0]        e_s1_reg;
    logic [2:0]        e_s2_reg;
    logic              e_zero_reg;

    for (genvar i = 0; i < 3; i++) begin : g_proj
        assign d_t1_full[i] = (K1W+UW)'(d_k1_reg) * (K1W+UW)'(d_umag_reg[i]);
        assign d_t2_full[i] = (K2W+UW)'(d_k2_reg) * (K2W+UW)'(d_umag_reg[i]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
        end else if (en) begin
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                e_t1_reg[i] <= d_t1_full[i][K1W+FRAC_BITS-1:FRAC_BITS];
                e_t2_reg[i] <= d_t2_full[i][K2W+FRAC_BITS-1:FRAC_BITS];
                e_s1_reg[i] <= d_sneg_reg ^ d_dneg_reg[i];
                e_s2_reg[i] <= d_pneg_reg ^ d_dneg_reg[i];
            end
            e_zero_reg <= d_zero_reg;
        end
    end

    // combine, saturate
    logic signed [FW-1:0] e_sum [3];
    logic [W-1:0]         e_force [3];
    logic [2:0]           e_clip;
    logic                 m_valid_reg;
    dsf_pkg::spring_out_t m_data_reg;
    dsf_pkg::spring_out_t m_data_next;

    for (genvar i = 0; i < 3; i++) begin : g_sat
        logic signed [FW-1:0] t1;
        logic signed [FW-1:0] t2;

        assign t1 = e_s1_reg[i] ? -$signed(FW'(e_t1_reg[i])) : $signed(FW'(e_t1_reg[i]));
        assign t2 = e_s2_reg[i] ? -$signed(FW'(e_t2_reg[i])) : $signed(FW'(e_t2_reg[i]));
        assign e_sum[i]  = t1 + t2;
        assign e_clip[i] = !((e_sum[i][FW-1:W-1] == '0) || (e_sum[i][FW-1:W-1] == '1));
        assign e_force[i] = e_clip[i] ? (e_sum[i][FW-1] ? SAT_NEG : SAT_POS)
                                      : e_sum[i][W-1:0];
    end

    always_comb begin
        m_data_next.force_x     = e_zero_reg ? '0 : e_force[0];
        m_data_next.force_y     = e_zero_reg ? '0 : e_force[1];
        m_data_next.force_z     = e_zero_reg ? '0 : e_force[2];
        m_data_next.zero_length = e_zero_reg;
        m_data_next.saturated   = !e_zero_reg && (e_clip != 3'b000);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`include "damped_spring_force_core_assert.svh"

    `DSF_ASSERT_NEXT(a_accept_enters, aclk, aresetn, s_valid && s_ready, p0_valid_reg, "accepted word lost at entry")
    `DSF_ASSERT_NEXT(a_stall_holds, aclk, aresetn, e_valid_reg && m_valid && !m_ready, e_valid_reg && m_valid, "pipeline moved during stall")
    `DSF_ASSERT_NOW(a_zero_quiet, aclk, aresetn, m_valid && m_data.zero_length, m_data.force_x == '0 && m_data.force_y == '0 && m_data.force_z == '0 && !m_data.saturated, "zero length with nonzero force")
    `DSF_ASSERT_NOW(a_sat_at_limit, aclk, aresetn, m_valid && m_data.saturated, m_data.force_x == SAT_POS || m_data.force_x == SAT_NEG || m_data.force_y == SAT_POS || m_data.force_y == SAT_NEG || m_data.force_z == SAT_POS || m_data.force_z == SAT_NEG, "saturation flag without a clipped component")

endmodule
